>>> hw/rtl/ps2a_pkg.sv
// Shared types and constants for the PS/2 set-2 scan code to ASCII decoder.
`timescale 1ns / 1ps
`default_nettype none

package ps2a_pkg;

    // Special scan bytes
    localparam logic [7:0] BYTE_NONE   = 8'h00;
    localparam logic [7:0] BYTE_EXT    = 8'he0;
    localparam logic [7:0] BYTE_BREAK  = 8'hf0;
    localparam logic [7:0] CODE_LSHIFT = 8'h12;
    localparam logic [7:0] CODE_RSHIFT = 8'h59;
    localparam logic [7:0] CODE_CTRL   = 8'h14;
    localparam logic [7:0] CODE_ALT    = 8'h11;

    // Modifier flag bits
    localparam logic [2:0] MOD_NONE  = 3'b000;
    localparam logic [2:0] MOD_SHIFT = 3'b001;
    localparam logic [2:0] MOD_CTRL  = 3'b010;
    localparam logic [2:0] MOD_ALT   = 3'b100;

    // Decode phases
    localparam logic [1:0] PH_NORMAL    = 2'd0;
    localparam logic [1:0] PH_BREAK     = 2'd1;
    localparam logic [1:0] PH_EXT       = 2'd2;
    localparam logic [1:0] PH_EXT_BREAK = 2'd3;

    // Lookup result: hit flag and translated character
    typedef struct packed {
        logic       hit;
        logic [6:0] ch;
    } lookup_t;

endpackage

`default_nettype wire

>>> hw/rtl/ps2a_rom.sv
// Character ROM: scan byte plus exact modifier set to ASCII.
`timescale 1ns / 1ps
`default_nettype none

module ps2a_rom
(
    input  wire logic [7:0]      code,
    input  wire logic [2:0]      mods,
    output ps2a_pkg::lookup_t    result
);

    localparam logic [2:0] MN  = ps2a_pkg::MOD_NONE;
    localparam logic [2:0] MS  = ps2a_pkg::MOD_SHIFT;
    localparam logic [2:0] MC  = ps2a_pkg::MOD_CTRL;
    localparam logic [2:0] MCS = ps2a_pkg::MOD_CTRL | ps2a_pkg::MOD_SHIFT;

    logic       rom_hit;
    logic [6:0] rom_char;

    always_comb
    begin
        rom_hit = 1'b1;
        unique case ({mods, code})
            // control characters
            {MCS, 8'h1e}: rom_char = 7'h00;
            {MC, 8'h1c}: rom_char = 7'h01;
            {MC, 8'h32}: rom_char = 7'h02;
            {MC, 8'h21}: rom_char = 7'h03;
            {MC, 8'h23}: rom_char = 7'h04;
            {MC, 8'h24}: rom_char = 7'h05;
            {MC, 8'h2b}: rom_char = 7'h06;
            {MC, 8'h34}: rom_char = 7'h07;
            {MC, 8'h33}: rom_char = 7'h08;
            {MN, 8'h66}: rom_char = 7'h08;
            {MC, 8'h43}: rom_char = 7'h09;
            {MN, 8'h0d}: rom_char = 7'h09;
            {MC, 8'h3b}: rom_char = 7'h0a;
            {MC, 8'h42}: rom_char = 7'h0b;
            {MC, 8'h4b}: rom_char = 7'h0c;
            {MC, 8'h3a}: rom_char = 7'h0d;
            {MC, 8'h31}: rom_char = 7'h0e;
            {MC, 8'h44}: rom_char = 7'h0f;
            {MC, 8'h4d}: rom_char = 7'h10;
            {MC, 8'h15}: rom_char = 7'h11;
            {MC, 8'h20}: rom_char = 7'h12;
            {MC, 8'h1b}: rom_char = 7'h13;
            {MC, 8'h2c}: rom_char = 7'h14;
            {MC, 8'h3c}: rom_char = 7'h15;
            {MC, 8'h2a}: rom_char = 7'h16;
            {MC, 8'h1d}: rom_char = 7'h17;
            {MC, 8'h22}: rom_char = 7'h18;
            {MC, 8'h35}: rom_char = 7'h19;
            {MC, 8'h1a}: rom_char = 7'h1a;
            {MN, 8'h76}: rom_char = 7'h1b;
            {MC, 8'h5d}: rom_char = 7'h1c;
            {MC, 8'h5b}: rom_char = 7'h1d;
            {MCS, 8'h36}: rom_char = 7'h1e;
            {MCS, 8'h4e}: rom_char = 7'h1f;
            // lower case
            {MN, 8'h1c}: rom_char = 7'h61;
            {MN, 8'h32}: rom_char = 7'h62;
            {MN, 8'h21}: rom_char = 7'h63;
            {MN, 8'h23}: rom_char = 7'h64;
            {MN, 8'h24}: rom_char = 7'h65;
            {MN, 8'h2b}: rom_char = 7'h66;
            {MN, 8'h34}: rom_char = 7'h67;
            {MN, 8'h33}: rom_char = 7'h68;
            {MN, 8'h43}: rom_char = 7'h69;
            {MN, 8'h3b}: rom_char = 7'h6a;
            {MN, 8'h42}: rom_char = 7'h6b;
            {MN, 8'h4b}: rom_char = 7'h6c;
            {MN, 8'h3a}: rom_char = 7'h6d;
            {MN, 8'h31}: rom_char = 7'h6e;
            {MN, 8'h44}: rom_char = 7'h6f;
            {MN, 8'h4d}: rom_char = 7'h70;
            {MN, 8'h15}: rom_char = 7'h71;
            {MN, 8'h20}: rom_char = 7'h72;
            {MN, 8'h1b}: rom_char = 7'h73;
            {MN, 8'h2c}: rom_char = 7'h74;
            {MN, 8'h3c}: rom_char = 7'h75;
            {MN, 8'h2a}: rom_char = 7'h76;
            {MN, 8'h1d}: rom_char = 7'h77;
            {MN, 8'h22}: rom_char = 7'h78;
            {MN, 8'h35}: rom_char = 7'h79;
            {MN, 8'h1a}: rom_char = 7'h7a;
            // upper case
            {MS, 8'h1c}: rom_char = 7'h41;
            {MS, 8'h32}: rom_char = 7'h42;
            {MS, 8'h21}: rom_char = 7'h43;
            {MS, 8'h23}: rom_char = 7'h44;
            {MS, 8'h24}: rom_char = 7'h45;
            {MS, 8'h2b}: rom_char = 7'h46;
            {MS, 8'h34}: rom_char = 7'h47;
            {MS, 8'h33}: rom_char = 7'h48;
            {MS, 8'h43}: rom_char = 7'h49;
            {MS, 8'h3b}: rom_char = 7'h4a;
            {MS, 8'h42}: rom_char = 7'h4b;
            {MS, 8'h4b}: rom_char = 7'h4c;
            {MS, 8'h3a}: rom_char = 7'h4d;
            {MS, 8'h31}: rom_char = 7'h4e;
            {MS, 8'h44}: rom_char = 7'h4f;
            {MS, 8'h4d}: rom_char = 7'h50;
            {MS, 8'h15}: rom_char = 7'h51;
            {MS, 8'h20}: rom_char = 7'h52;
            {MS, 8'h1b}: rom_char = 7'h53;
            {MS, 8'h2c}: rom_char = 7'h54;
            {MS, 8'h3c}: rom_char = 7'h55;
            {MS, 8'h2a}: rom_char = 7'h56;
            {MS, 8'h1d}: rom_char = 7'h57;
            {MS, 8'h22}: rom_char = 7'h58;
            {MS, 8'h35}: rom_char = 7'h59;
            {MS, 8'h1a}: rom_char = 7'h5a;
            // space and digits
            {MN, 8'h29}: rom_char = 7'h20;
            {MN, 8'h45}: rom_char = 7'h30;
            {MN, 8'h16}: rom_char = 7'h31;
            {MN, 8'h1e}: rom_char = 7'h32;
            {MN, 8'h26}: rom_char = 7'h33;
            {MN, 8'h25}: rom_char = 7'h34;
            {MN, 8'h2e}: rom_char = 7'h35;
            {MN, 8'h36}: rom_char = 7'h36;
            {MN, 8'h3d}: rom_char = 7'h37;
            {MN, 8'h3e}: rom_char = 7'h38;
            {MN, 8'h46}: rom_char = 7'h39;
            // punctuation
            {MN, 8'h4e}: rom_char = 7'h2d;
            {MN, 8'h55}: rom_char = 7'h3d;
            {MN, 8'h5d}: rom_char = 7'h5c;
            {MN, 8'h0e}: rom_char = 7'h60;
            {MN, 8'h54}: rom_char = 7'h5b;
            {MN, 8'h5b}: rom_char = 7'h5d;
            {MN, 8'h4c}: rom_char = 7'h3b;
            {MN, 8'h52}: rom_char = 7'h27;
            {MN, 8'h41}: rom_char = 7'h2c;
            {MN, 8'h49}: rom_char = 7'h2e;
            {MN, 8'h4a}: rom_char = 7'h2f;
            // shifted symbols
            {MS, 8'h16}: rom_char = 7'h21;
            {MS, 8'h1e}: rom_char = 7'h40;
            {MS, 8'h26}: rom_char = 7'h23;
            {MS, 8'h25}: rom_char = 7'h24;
            {MS, 8'h2e}: rom_char = 7'h25;
            {MS, 8'h36}: rom_char = 7'h5e;
            {MS, 8'h3d}: rom_char = 7'h26;
            {MS, 8'h3e}: rom_char = 7'h2a;
            {MS, 8'h46}: rom_char = 7'h28;
            {MS, 8'h45}: rom_char = 7'h29;
            {MS, 8'h4e}: rom_char = 7'h5f;
            {MS, 8'h55}: rom_char = 7'h2b;
            {MS, 8'h5d}: rom_char = 7'h7c;
            {MS, 8'h0e}: rom_char = 7'h7e;
            {MS, 8'h54}: rom_char = 7'h7b;
            {MS, 8'h5b}: rom_char = 7'h7d;
            {MS, 8'h4c}: rom_char = 7'h3a;
            {MS, 8'h52}: rom_char = 7'h22;
            {MS, 8'h41}: rom_char = 7'h3c;
            {MS, 8'h49}: rom_char = 7'h3e;
            {MS, 8'h4a}: rom_char = 7'h3f;
            default:
            begin
                rom_hit  = 1'b0;
                rom_char = 7'h00;
            end
        endcase
    end

    assign result.hit = rom_hit;
    assign result.ch  = rom_char;

endmodule

`default_nettype wire

>>> hw/rtl/ps2a_decoder.sv
// Phase machine and modifier flags; translates one scan byte per beat.
`timescale 1ns / 1ps
`default_nettype none

module ps2a_decoder
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic [7:0]        scan_byte,
    output ps2a_pkg::lookup_t      result
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [2:0] mods_reg;
    logic [2:0] mods_next;
    logic       is_shift;
    logic       is_ctrl;
    logic       is_alt;
    logic       lookup_en;
    ps2a_pkg::lookup_t rom_result;

    assign is_shift = (scan_byte == ps2a_pkg::CODE_LSHIFT) ||
                      (scan_byte == ps2a_pkg::CODE_RSHIFT);
    assign is_ctrl  = (scan_byte == ps2a_pkg::CODE_CTRL);
    assign is_alt   = (scan_byte == ps2a_pkg::CODE_ALT);

    ps2a_rom u_rom
    (
        .code   (scan_byte),
        .mods   (mods_reg),
        .result (rom_result)
    );

    always_comb
    begin
        phase_next = phase_reg;
        mods_next  = mods_reg;
        lookup_en  = 1'b0;
        if (scan_byte != ps2a_pkg::BYTE_NONE)
        begin
            unique case (phase_reg)
                ps2a_pkg::PH_NORMAL:
                begin
                    priority if (scan_byte == ps2a_pkg::BYTE_EXT)
                        phase_next = ps2a_pkg::PH_EXT;
                    else if (scan_byte == ps2a_pkg::BYTE_BREAK)
                        phase_next = ps2a_pkg::PH_BREAK;
                    else if (is_ctrl)
                        mods_next = mods_reg | ps2a_pkg::MOD_CTRL;
                    else if (is_alt)
                        mods_next = mods_reg | ps2a_pkg::MOD_ALT;
                    else if (is_shift)
                        mods_next = mods_reg | ps2a_pkg::MOD_SHIFT;
                    else
                        lookup_en = 1'b1;
                end
                ps2a_pkg::PH_BREAK:
                begin
                    if (is_ctrl)
                        mods_next = mods_reg & ~ps2a_pkg::MOD_CTRL;
                    else if (is_alt)
                        mods_next = mods_reg & ~ps2a_pkg::MOD_ALT;
                    else if (is_shift)
                        mods_next = mods_reg & ~ps2a_pkg::MOD_SHIFT;
                    phase_next = ps2a_pkg::PH_NORMAL;
                end
                ps2a_pkg::PH_EXT:
                begin
                    if (scan_byte == ps2a_pkg::BYTE_BREAK)
                        phase_next = ps2a_pkg::PH_EXT_BREAK;
                    else
                    begin
                        // anything else ends the extended sequence
                        if (is_ctrl)
                            mods_next = mods_reg | ps2a_pkg::MOD_CTRL;
                        else if (is_alt)
                            mods_next = mods_reg | ps2a_pkg::MOD_ALT;
                        phase_next = ps2a_pkg::PH_NORMAL;
                    end
                end
                default:
                begin
                    if (is_ctrl)
                        mods_next = mods_reg & ~ps2a_pkg::MOD_CTRL;
                    else if (is_alt)
                        mods_next = mods_reg & ~ps2a_pkg::MOD_ALT;
                    phase_next = ps2a_pkg::PH_NORMAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ps2a_pkg::PH_NORMAL;
            mods_reg  <= ps2a_pkg::MOD_NONE;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            mods_reg  <= mods_next;
        end
    end

    assign result.hit = lookup_en & rom_result.hit;
    assign result.ch  = rom_result.ch;

endmodule

`default_nettype wire

>>> hw/rtl/ps2_scan_code_to_ascii_top.sv
// Top level of the PS/2 set-2 scan code to ASCII decoder.
//
//   Channel   Dir  Bits  Contents
//   s_axis    in   8     tdata[7:0] scan_byte
//   m_axis    out  8     tdata[6:0] ascii_char, tdata[7] zero
//
// One scan byte per cycle, sustained while the output is not stalled. A beat
// lands in the input register, the phase machine and character ROM decode it
// from there, and a hit loads the output register. Bytes that give no
// character leave no output beat. Reset: normal phase, no modifiers held. An
// output stall holds the output register and, once the input register is also
// full, drops s_axis_tready.
`timescale 1ns / 1ps
`default_nettype none

module ps2_scan_code_to_ascii_top
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] scan_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [6:0] ascii_char, [7] zero
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [6:0] out_char_reg;
    logic       out_free;
    logic       in_fire;
    logic       decode_advance;
    ps2a_pkg::lookup_t decode_result;

    // The output register can take a new result when empty or being drained.
    assign out_free       = !out_valid_reg || m_axis_tready;
    // Advance the decode stage whenever it holds a byte and the output can take it.
    assign decode_advance = in_valid_reg && out_free;
    assign s_axis_tready  = !in_valid_reg || out_free;
    assign in_fire        = s_axis_tvalid && s_axis_tready;

    ps2a_decoder u_decoder
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (decode_advance),
        .scan_byte (in_byte_reg),
        .result    (decode_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (decode_advance)
            in_valid_next = 1'b0;

        // Hold a stalled result; otherwise load the decode outcome.
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = decode_advance && decode_result.hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_byte_reg <= s_axis_tdata;
        if (decode_advance && decode_result.hit)
            out_char_reg <= decode_result.ch;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_char_reg};

`ifndef SYNTHESIS
    // A fresh output beat can only come from a byte held in the decode stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("output beat appeared without a decoded byte");

    // An empty input register must always accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled while input register empty");

    // A stalled output with a held byte must keep that byte in the decode stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready && in_valid_reg) |=>
            (in_valid_reg && $stable(in_byte_reg)))
        else $error("decode stage advanced during output stall");
`endif

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking stream testbench for the PS/2 set-2 scan code to ASCII decoder.
`timescale 1ns / 1ps

module tb_top;

    // Cycles with no beat on either side before the run is declared hung.
    // The longest legal quiet stretch is a long receiver hold,
    // so this leaves a wide margin.
    localparam int unsigned HANG_LIMIT = 4000;
    localparam int unsigned RANDOM_KEYS = 1300;

    localparam logic [2:0] MODS_CS = ps2a_pkg::MOD_CTRL | ps2a_pkg::MOD_SHIFT;

    // Scan codes of the letter keys a..z, in alphabet order
    localparam logic [0:25][7:0] LETTER_CODES = {
        8'h1c, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2b, 8'h34, 8'h33, 8'h43,
        8'h3b, 8'h42, 8'h4b, 8'h3a, 8'h31, 8'h44, 8'h4d, 8'h15, 8'h20,
        8'h1b, 8'h2c, 8'h3c, 8'h2a, 8'h1d, 8'h22, 8'h35, 8'h1a
    };

    // Digit and punctuation keys with their plain and shifted characters
    localparam logic [0:20][7:0] SYMBOL_CODES = {
        8'h45, 8'h16, 8'h1e, 8'h26, 8'h25, 8'h2e, 8'h36, 8'h3d, 8'h3e, 8'h46,
        8'h4e, 8'h55, 8'h5d, 8'h0e, 8'h54, 8'h5b, 8'h4c, 8'h52, 8'h41, 8'h49,
        8'h4a
    };
    localparam logic [0:20][7:0] SYMBOL_PLAIN = {
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h2d, 8'h3d, 8'h5c, 8'h60, 8'h5b, 8'h5d, 8'h3b, 8'h27, 8'h2c, 8'h2e,
        8'h2f
    };
    localparam logic [0:20][7:0] SYMBOL_SHIFTED = {
        8'h29, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28,
        8'h5f, 8'h2b, 8'h7c, 8'h7e, 8'h7b, 8'h7d, 8'h3a, 8'h22, 8'h3c, 8'h3e,
        8'h3f
    };

    // One pending input beat: the scan byte, the idle cycles that follow its
    // acceptance, and whether the sender must wait for all characters first
    typedef struct {
        logic [7:0]  scan;
        int unsigned gap;
        bit          drain_first;
    } scan_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] scan_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [6:0] ascii_char, [7] zero

    scan_beat_t  scan_backlog[$];
    logic [6:0]  chars_due[$];

    // Shadow copy of the decoder state
    logic [1:0]  kb_phase = ps2a_pkg::PH_NORMAL;
    logic [2:0]  held_mods = ps2a_pkg::MOD_NONE;

    int unsigned keys_queued = 0;
    int unsigned chars_seen = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    bit          in_beat_taken = 1'b0;

    int unsigned gap_left = 0;
    int unsigned gap_after_cur = 0;
    int unsigned hold_left = 0;
    int unsigned next_long_hold = 60;

    ps2_scan_code_to_ascii_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    // Character map: a key translates only under an exact modifier set.
    function automatic bit keymap_lookup(input logic [7:0] code, input logic [2:0] mods,
                                         output logic [6:0] ch);
        bit hit;
        int i;
        hit = 1'b0;
        ch = '0;
        for (i = 0; i < 26; i++)
        begin
            if (code == LETTER_CODES[i])
            begin
                if (mods == ps2a_pkg::MOD_NONE)
                begin
                    hit = 1'b1;
                    ch = 7'(97 + i);
                end
                else if (mods == ps2a_pkg::MOD_SHIFT)
                begin
                    hit = 1'b1;
                    ch = 7'(65 + i);
                end
                else if (mods == ps2a_pkg::MOD_CTRL)
                begin
                    hit = 1'b1;
                    ch = 7'(1 + i);
                end
            end
        end
        for (i = 0; i < 21; i++)
        begin
            if (code == SYMBOL_CODES[i])
            begin
                if (mods == ps2a_pkg::MOD_NONE)
                begin
                    hit = 1'b1;
                    ch = SYMBOL_PLAIN[i][6:0];
                end
                else if (mods == ps2a_pkg::MOD_SHIFT)
                begin
                    hit = 1'b1;
                    ch = SYMBOL_SHIFTED[i][6:0];
                end
            end
        end
        // Space, editing keys, NUL and the control characters past ctrl-z
        case ({mods, code})
            {ps2a_pkg::MOD_NONE, 8'h29}: begin hit = 1'b1; ch = 7'h20; end
            {ps2a_pkg::MOD_NONE, 8'h66}: begin hit = 1'b1; ch = 7'h08; end
            {ps2a_pkg::MOD_NONE, 8'h0d}: begin hit = 1'b1; ch = 7'h09; end
            {ps2a_pkg::MOD_NONE, 8'h76}: begin hit = 1'b1; ch = 7'h1b; end
            {ps2a_pkg::MOD_CTRL, 8'h5d}: begin hit = 1'b1; ch = 7'h1c; end
            {ps2a_pkg::MOD_CTRL, 8'h5b}: begin hit = 1'b1; ch = 7'h1d; end
            {MODS_CS, 8'h1e}:            begin hit = 1'b1; ch = 7'h00; end
            {MODS_CS, 8'h36}:            begin hit = 1'b1; ch = 7'h1e; end
            {MODS_CS, 8'h4e}:            begin hit = 1'b1; ch = 7'h1f; end
            default: ;
        endcase
        return hit;
    endfunction

    // Advance the shadow phase machine by one accepted byte and record the
    // character it should produce, if any.
    function automatic void advance_decoder(input logic [7:0] b);
        logic [6:0] ch;
        if (b != ps2a_pkg::BYTE_NONE)
        begin
            case (kb_phase)
                ps2a_pkg::PH_NORMAL:
                begin
                    if (b == ps2a_pkg::BYTE_EXT)
                        kb_phase = ps2a_pkg::PH_EXT;
                    else if (b == ps2a_pkg::BYTE_BREAK)
                        kb_phase = ps2a_pkg::PH_BREAK;
                    else if (b == ps2a_pkg::CODE_CTRL)
                        held_mods = held_mods | ps2a_pkg::MOD_CTRL;
                    else if (b == ps2a_pkg::CODE_ALT)
                        held_mods = held_mods | ps2a_pkg::MOD_ALT;
                    else if (b == ps2a_pkg::CODE_LSHIFT || b == ps2a_pkg::CODE_RSHIFT)
                        held_mods = held_mods | ps2a_pkg::MOD_SHIFT;
                    else if (keymap_lookup(b, held_mods, ch))
                        chars_due.push_back(ch);
                end
                ps2a_pkg::PH_BREAK:
                begin
                    if (b == ps2a_pkg::CODE_CTRL)
                        held_mods = held_mods & ~ps2a_pkg::MOD_CTRL;
                    else if (b == ps2a_pkg::CODE_ALT)
                        held_mods = held_mods & ~ps2a_pkg::MOD_ALT;
                    else if (b == ps2a_pkg::CODE_LSHIFT || b == ps2a_pkg::CODE_RSHIFT)
                        held_mods = held_mods & ~ps2a_pkg::MOD_SHIFT;
                    kb_phase = ps2a_pkg::PH_NORMAL;
                end
                ps2a_pkg::PH_EXT:
                begin
                    // Only a break byte keeps the extended sequence going
                    if (b == ps2a_pkg::BYTE_BREAK)
                        kb_phase = ps2a_pkg::PH_EXT_BREAK;
                    else
                    begin
                        if (b == ps2a_pkg::CODE_CTRL)
                            held_mods = held_mods | ps2a_pkg::MOD_CTRL;
                        else if (b == ps2a_pkg::CODE_ALT)
                            held_mods = held_mods | ps2a_pkg::MOD_ALT;
                        kb_phase = ps2a_pkg::PH_NORMAL;
                    end
                end
                default:
                begin
                    if (b == ps2a_pkg::CODE_CTRL)
                        held_mods = held_mods & ~ps2a_pkg::MOD_CTRL;
                    else if (b == ps2a_pkg::CODE_ALT)
                        held_mods = held_mods & ~ps2a_pkg::MOD_ALT;
                    kb_phase = ps2a_pkg::PH_NORMAL;
                end
            endcase
        end
    endfunction

    // Idle cycles after a beat: mostly none or short, a few long, and one
    // stretch of back-to-back beats.
    function automatic int unsigned pick_scan_gap(input int unsigned idx);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (idx >= 300 && idx < 450)
            return 0;
        else if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [7:0] pick_typed_code();
        int unsigned r;
        r = $urandom_range(0, 50);
        if (r < 26)
            return LETTER_CODES[r[4:0]];
        else if (r < 47)
            return SYMBOL_CODES[5'(r - 26)];
        case (r)
            47:      return 8'h29;
            48:      return 8'h66;
            49:      return 8'h0d;
            default: return 8'h76;
        endcase
    endfunction

    function automatic logic [7:0] pick_modifier();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return ps2a_pkg::CODE_LSHIFT;
        else if (r < 5)
            return ps2a_pkg::CODE_RSHIFT;
        else if (r < 8)
            return ps2a_pkg::CODE_CTRL;
        return ps2a_pkg::CODE_ALT;
    endfunction

    // Append one byte to the backlog. Twice in the run the sender is made
    // to wait until every pending character has come back.
    function automatic void queue_scan(input logic [7:0] b);
        scan_beat_t beat;
        beat.scan = b;
        beat.gap = pick_scan_gap(keys_queued);
        beat.drain_first = (b != ps2a_pkg::BYTE_NONE) &&
                           (keys_queued == 500 || keys_queued == 1000);
        scan_backlog.push_back(beat);
        if (b != ps2a_pkg::BYTE_NONE)
            keys_queued++;
    endfunction

    // Prefix byte, now and then followed by a zero byte that must be ignored
    // without disturbing the sequence.
    function automatic void queue_prefix(input logic [7:0] b);
        queue_scan(b);
        if ($urandom_range(0, 9) == 0)
            queue_scan(ps2a_pkg::BYTE_NONE);
    endfunction

    // Driver: change inputs on the falling edge; hold a beat until taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (s_axis_tvalid && !in_beat_taken)
            ;
        else if (s_axis_tvalid && gap_after_cur != 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left <= gap_after_cur - 1;
        end
        else if (gap_left != 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (scan_backlog.size() != 0 &&
                 !(scan_backlog[0].drain_first && chars_due.size() != 0))
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= scan_backlog[0].scan;
            gap_after_cur <= scan_backlog[0].gap;
            void'(scan_backlog.pop_front());
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // Receiver: random stalls, a no-stall stretch, and two long holds that
    // fill the block and push back on the input side.
    always @(negedge clk)
    begin
        int unsigned r;
        r = $urandom_range(0, 99);
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (chars_seen >= next_long_hold)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 249;
            next_long_hold <= (next_long_hold == 60) ? 500 : 32'hffff_ffff;
        end
        else if ((chars_seen >= 150 && chars_seen < 300) || r < 60)
            m_axis_tready <= 1'b1;
        else
        begin
            m_axis_tready <= 1'b0;
            if (r < 90)
                hold_left <= $urandom_range(0, 2);
            else if (r < 98)
                hold_left <= $urandom_range(3, 11);
            else
                hold_left <= $urandom_range(19, 79);
        end
    end

    // Monitor: sample both channels on the rising edge, predict on each
    // input beat, check each output beat, and watch for a hang.
    always @(posedge clk)
    begin
        logic [6:0] want;
        in_beat_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                chars_seen++;
                if (chars_due.size() == 0)
                begin
                    $error("ascii_char: expected no beat, got 0x%02h", m_axis_tdata[6:0]);
                    mismatches++;
                end
                else
                begin
                    want = chars_due.pop_front();
                    if (m_axis_tdata[6:0] !== want)
                    begin
                        $error("ascii_char: expected 0x%02h, got 0x%02h",
                               want, m_axis_tdata[6:0]);
                        mismatches++;
                    end
                end
                if (m_axis_tdata[7] !== 1'b0)
                begin
                    $error("tdata[7] pad: expected 0, got %b", m_axis_tdata[7]);
                    mismatches++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_decoder(s_axis_tdata);

            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= HANG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int unsigned r;
        logic [7:0] code;

        // Directed: zero byte, plain/shifted/control letters, ctrl-shift-2,
        // alt suppressing output, extended control make and break, extended
        // byte that is dropped, a zero inside an extended break, the top
        // byte value and escape.
        queue_scan(8'h00); queue_scan(8'h1c);
        queue_scan(ps2a_pkg::CODE_LSHIFT); queue_scan(8'h1c);
        queue_scan(ps2a_pkg::BYTE_BREAK); queue_scan(ps2a_pkg::CODE_LSHIFT);
        queue_scan(ps2a_pkg::CODE_CTRL);
        queue_scan(8'h1c); queue_scan(ps2a_pkg::CODE_RSHIFT); queue_scan(8'h1e);
        queue_scan(ps2a_pkg::BYTE_BREAK); queue_scan(ps2a_pkg::CODE_RSHIFT);
        queue_scan(ps2a_pkg::BYTE_BREAK);
        queue_scan(ps2a_pkg::CODE_CTRL); queue_scan(ps2a_pkg::CODE_ALT); queue_scan(8'h1c);
        queue_scan(ps2a_pkg::BYTE_BREAK); queue_scan(ps2a_pkg::CODE_ALT);
        queue_scan(ps2a_pkg::BYTE_EXT);
        queue_scan(ps2a_pkg::CODE_CTRL); queue_scan(8'h21); queue_scan(ps2a_pkg::BYTE_EXT);
        queue_scan(ps2a_pkg::BYTE_BREAK); queue_scan(8'h00); queue_scan(ps2a_pkg::CODE_CTRL);
        queue_scan(ps2a_pkg::BYTE_EXT); queue_scan(8'h75); queue_scan(8'hff);
        queue_scan(8'h76);

        // Random: mostly well-formed key sequences, some noise
        while (keys_queued < RANDOM_KEYS)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                code = pick_typed_code();
                queue_scan(code);
                if ($urandom_range(0, 9) < 7)
                begin
                    queue_prefix(ps2a_pkg::BYTE_BREAK);
                    queue_scan(code);
                end
            end
            else if (r < 58)
            begin
                code = pick_modifier();
                if ((code == ps2a_pkg::CODE_CTRL || code == ps2a_pkg::CODE_ALT) &&
                    $urandom_range(0, 1) == 1)
                    queue_prefix(ps2a_pkg::BYTE_EXT);
                queue_scan(code);
            end
            else if (r < 72)
            begin
                code = pick_modifier();
                if ((code == ps2a_pkg::CODE_CTRL || code == ps2a_pkg::CODE_ALT) &&
                    $urandom_range(0, 1) == 1)
                    queue_prefix(ps2a_pkg::BYTE_EXT);
                queue_prefix(ps2a_pkg::BYTE_BREAK);
                queue_scan(code);
            end
            else if (r < 82)
            begin
                queue_prefix(ps2a_pkg::BYTE_EXT);
                if ($urandom_range(0, 1) == 1)
                    queue_prefix(ps2a_pkg::BYTE_BREAK);
                queue_scan(8'($urandom_range(1, 255)));
            end
            else if (r < 87)
                queue_scan(ps2a_pkg::BYTE_NONE);
            else
                queue_scan(8'($urandom_range(0, 255)));
        end

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Let the backlog drain, then every character come back
        while (scan_backlog.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (chars_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
